[hw/rtl/ncrm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrm_pkg
// Shared widths, types and helpers for the crop-and-resize mapper.
// ----------------------------------------------------------------------------
package ncrm_pkg;

    localparam int BYTES_PER_PIXEL = 3;
    localparam int MAX_DIM         = 4096;

    localparam int REG_W    = 13;                        // config data width
    localparam int IDX_W    = 3;                         // config index width
    localparam int POS_W    = 12;                        // destination coordinate
    localparam int COORD_W  = 12;                        // source coordinate field
    localparam int OFF_W    = 26;                        // byte offset field
    localparam int DIM_W    = $clog2(MAX_DIM + 1);       // effective size
    localparam int NUM_W    = POS_W + DIM_W;             // dividend / quotient
    localparam int PROD_W   = COORD_W + DIM_W;           // row times width
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 3'd0,
        REG_SOURCE_HEIGHT = 3'd1,
        REG_TARGET_WIDTH  = 3'd2,
        REG_TARGET_HEIGHT = 3'd3,
        REG_CROP_LEFT     = 3'd4,
        REG_CROP_TOP      = 3'd5,
        REG_CROP_SPAN_X   = 3'd6,
        REG_CROP_SPAN_Y   = 3'd7
    } ncrm_reg_idx_t;

    // Effective (saturated) configuration as used by the datapath
    typedef struct packed {
        logic [DIM_W-1:0]        src_w;
        logic [DIM_W-1:0]        src_h;
        logic [DIM_W-1:0]        tgt_w;
        logic [DIM_W-1:0]        tgt_h;
        logic signed [REG_W-1:0] crop_left;
        logic signed [REG_W-1:0] crop_top;
        logic [DIM_W-1:0]        span_x;
        logic [DIM_W-1:0]        span_y;
    } ncrm_cfg_t;

    // Queue entry between front and back
    typedef struct packed {
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [OFF_W-1:0] dst_off;
    } ncrm_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ncrm_fifo_stat_t;

    // Restoring divider state: partial remainder and dividend/quotient shifter
    typedef struct packed {
        logic [DIM_W-1:0] rem;
        logic [NUM_W-1:0] nq;
    } ncrm_div_t;

    function automatic logic [DIM_W-1:0] eff_size(input logic [REG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (REG_W'(v) > REG_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(v);
        return r;
    endfunction

    // One quotient bit per call
    function automatic ncrm_div_t div_step(input ncrm_div_t s, input logic [DIM_W-1:0] d);
        logic [DIM_W:0] t;
        logic           ge;
        ncrm_div_t      r;
        t  = {s.rem, s.nq[NUM_W-1]};
        ge = (t >= {1'b0, d});
        r.rem = ge ? DIM_W'(t - {1'b0, d}) : DIM_W'(t);
        r.nq  = {s.nq[NUM_W-2:0], ge};
        return r;
    endfunction

endpackage

[hw/rtl/ncrm_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrm_ifs
// Valid/ready channels of the mapper: pixel request in, mapping out, config.
// ----------------------------------------------------------------------------
interface ncrm_pix_in_if;
    logic                        valid;
    logic                        ready;
    logic [ncrm_pkg::POS_W-1:0]  out_col;
    logic [ncrm_pkg::POS_W-1:0]  out_row;

    modport source (output valid, output out_col, output out_row, input ready);
    modport sink   (input valid, input out_col, input out_row, output ready);
endinterface

interface ncrm_pix_out_if;
    logic                          valid;
    logic                          ready;
    logic [ncrm_pkg::COORD_W-1:0]  in_col;
    logic [ncrm_pkg::COORD_W-1:0]  in_row;
    logic [ncrm_pkg::OFF_W-1:0]    src_byte_offset;
    logic [ncrm_pkg::OFF_W-1:0]    dst_byte_offset;

    modport source (output valid, output in_col, output in_row,
                    output src_byte_offset, output dst_byte_offset, input ready);
    modport sink   (input valid, input in_col, input in_row,
                    input src_byte_offset, input dst_byte_offset, output ready);
endinterface

interface ncrm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ncrm_pkg::IDX_W-1:0]  index;
    logic [ncrm_pkg::REG_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/ncrm_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrm_cfg_regs
// Configuration registers; sizes are stored already saturated to 1..MAX_DIM.
// ----------------------------------------------------------------------------
module ncrm_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    ncrm_cfg_if.sink            cfg,
    output ncrm_pkg::ncrm_cfg_t cfg_q
);

    ncrm_pkg::ncrm_cfg_t cfg_reg;
    ncrm_pkg::ncrm_cfg_t cfg_next;
    logic [ncrm_pkg::DIM_W-1:0] size_w;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;
    assign size_w    = ncrm_pkg::eff_size(cfg.data);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (ncrm_pkg::ncrm_reg_idx_t'(cfg.index))
                ncrm_pkg::REG_SOURCE_WIDTH:  cfg_next.src_w     = size_w;
                ncrm_pkg::REG_SOURCE_HEIGHT: cfg_next.src_h     = size_w;
                ncrm_pkg::REG_TARGET_WIDTH:  cfg_next.tgt_w     = size_w;
                ncrm_pkg::REG_TARGET_HEIGHT: cfg_next.tgt_h     = size_w;
                ncrm_pkg::REG_CROP_LEFT:     cfg_next.crop_left = $signed(cfg.data);
                ncrm_pkg::REG_CROP_TOP:      cfg_next.crop_top  = $signed(cfg.data);
                ncrm_pkg::REG_CROP_SPAN_X:   cfg_next.span_x    = size_w;
                ncrm_pkg::REG_CROP_SPAN_Y:   cfg_next.span_y    = size_w;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_w     <= ncrm_pkg::DIM_W'(640);
            cfg_reg.src_h     <= ncrm_pkg::DIM_W'(480);
            cfg_reg.tgt_w     <= ncrm_pkg::DIM_W'(112);
            cfg_reg.tgt_h     <= ncrm_pkg::DIM_W'(112);
            cfg_reg.crop_left <= '0;
            cfg_reg.crop_top  <= '0;
            cfg_reg.span_x    <= ncrm_pkg::DIM_W'(640);
            cfg_reg.span_y    <= ncrm_pkg::DIM_W'(480);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hw/rtl/ncrm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrm_front
// Takes pixel requests, forms the dividends and the destination offset.
// ----------------------------------------------------------------------------
module ncrm_front (
    input  logic                     clk,
    input  logic                     rst_n,
    ncrm_pix_in_if.sink              pix_in,
    input  ncrm_pkg::ncrm_cfg_t      cfg_q,
    input  ncrm_pkg::ncrm_fifo_stat_t fifo_stat,
    output logic                     push,
    output ncrm_pkg::ncrm_item_t     push_item
);

    logic                          s1_vld_reg;
    logic                          s1_vld_next;
    logic [ncrm_pkg::NUM_W-1:0]    num_x_reg;
    logic [ncrm_pkg::NUM_W-1:0]    num_y_reg;
    logic [ncrm_pkg::PROD_W-1:0]   row_prod_reg;
    logic [ncrm_pkg::POS_W-1:0]    col_reg;
    logic                          take;
    logic [ncrm_pkg::OFF_W-1:0]    dst_sum;

    assign pix_in.ready = !s1_vld_reg || !fifo_stat.full;
    assign take         = pix_in.valid && pix_in.ready;
    assign push         = s1_vld_reg && !fifo_stat.full;

    // Offsets wrap at the field width
    assign dst_sum = ncrm_pkg::OFF_W'(row_prod_reg) + ncrm_pkg::OFF_W'(col_reg);
    assign push_item.num_x   = num_x_reg;
    assign push_item.num_y   = num_y_reg;
    assign push_item.dst_off = ncrm_pkg::OFF_W'(dst_sum * ncrm_pkg::BYTES_PER_PIXEL);

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (take)
            s1_vld_next = 1'b1;
        else if (push)
            s1_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= s1_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            num_x_reg    <= ncrm_pkg::NUM_W'(pix_in.out_col)
                            * ncrm_pkg::NUM_W'(cfg_q.span_x);
            num_y_reg    <= ncrm_pkg::NUM_W'(pix_in.out_row)
                            * ncrm_pkg::NUM_W'(cfg_q.span_y);
            row_prod_reg <= ncrm_pkg::PROD_W'(pix_in.out_row)
                            * ncrm_pkg::PROD_W'(cfg_q.tgt_w);
            col_reg      <= pix_in.out_col;
        end
    end

    // A held request must not be overwritten before it reaches the queue
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && !push |=> s1_vld_reg && $stable(num_x_reg) && $stable(col_reg))
        else $error("front stage lost a request");

endmodule

[hw/rtl/ncrm_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrm_fifo
// Short queue decoupling the front stage from the divider pipeline.
// ----------------------------------------------------------------------------
module ncrm_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  ncrm_pkg::ncrm_item_t      push_item,
    input  logic                      pop,
    output ncrm_pkg::ncrm_item_t      pop_item,
    output ncrm_pkg::ncrm_fifo_stat_t stat
);

    localparam int PTR_W = $clog2(ncrm_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(ncrm_pkg::FIFO_DEPTH + 1);

    ncrm_pkg::ncrm_item_t mem [ncrm_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign stat.full  = (count_reg == CNT_W'(ncrm_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(ncrm_pkg::FIFO_DEPTH - 1))
                              ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(ncrm_pkg::FIFO_DEPTH - 1))
                              ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("queue read while empty");

endmodule

[hw/rtl/ncrm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrm_back
// Pipelined restoring dividers, clamp, source offset and output register.
// ----------------------------------------------------------------------------
module ncrm_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ncrm_pkg::ncrm_cfg_t       cfg_q,
    input  ncrm_pkg::ncrm_fifo_stat_t fifo_stat,
    input  ncrm_pkg::ncrm_item_t      pop_item,
    output logic                      pop,
    ncrm_pix_out_if.source            pix_out
);

    localparam int NSTG  = ncrm_pkg::NUM_W;
    localparam int SUM_W = ncrm_pkg::NUM_W + 2;

    logic                          adv;
    ncrm_pkg::ncrm_div_t           init_x;
    ncrm_pkg::ncrm_div_t           init_y;

    logic [NSTG-1:0]               vld_reg;
    ncrm_pkg::ncrm_div_t           dx_reg  [NSTG];
    ncrm_pkg::ncrm_div_t           dy_reg  [NSTG];
    logic [ncrm_pkg::OFF_W-1:0]    dst_reg [NSTG];

    logic                          c_vld_reg;
    logic [ncrm_pkg::COORD_W-1:0]  c_sx_reg;
    logic [ncrm_pkg::COORD_W-1:0]  c_sy_reg;
    logic [ncrm_pkg::OFF_W-1:0]    c_dst_reg;

    logic                          m_vld_reg;
    logic [ncrm_pkg::COORD_W-1:0]  m_sx_reg;
    logic [ncrm_pkg::COORD_W-1:0]  m_sy_reg;
    logic [ncrm_pkg::PROD_W-1:0]   m_prod_reg;
    logic [ncrm_pkg::OFF_W-1:0]    m_dst_reg;
    logic [ncrm_pkg::OFF_W-1:0]    src_sum;

    logic                          out_vld_reg;
    logic [ncrm_pkg::COORD_W-1:0]  out_col_reg;
    logic [ncrm_pkg::COORD_W-1:0]  out_row_reg;
    logic [ncrm_pkg::OFF_W-1:0]    out_src_reg;
    logic [ncrm_pkg::OFF_W-1:0]    out_dst_reg;

    function automatic logic [ncrm_pkg::COORD_W-1:0] clamp_axis(
        input logic [ncrm_pkg::NUM_W-1:0]    q,
        input logic signed [ncrm_pkg::REG_W-1:0] org,
        input logic [ncrm_pkg::DIM_W-1:0]    size
    );
        logic signed [SUM_W-1:0]     s;
        logic [ncrm_pkg::DIM_W-1:0]  lim;
        logic [ncrm_pkg::COORD_W-1:0] r;
        s   = $signed({2'b00, q}) + SUM_W'(org);
        lim = size - ncrm_pkg::DIM_W'(1);
        if (s[SUM_W-1])
            r = '0;
        else if (s[SUM_W-2:0] > (SUM_W-1)'(lim))
            r = ncrm_pkg::COORD_W'(lim);
        else
            r = ncrm_pkg::COORD_W'(s[SUM_W-2:0]);
        return r;
    endfunction

    // The whole pipeline moves together whenever the output register is free
    assign adv = !out_vld_reg || pix_out.ready;
    assign pop = adv && !fifo_stat.empty;

    assign init_x.rem = '0;
    assign init_x.nq  = pop_item.num_x;
    assign init_y.rem = '0;
    assign init_y.nq  = pop_item.num_y;

    assign src_sum = ncrm_pkg::OFF_W'(m_prod_reg) + ncrm_pkg::OFF_W'(m_sx_reg);

    assign pix_out.valid           = out_vld_reg;
    assign pix_out.in_col          = out_col_reg;
    assign pix_out.in_row          = out_row_reg;
    assign pix_out.src_byte_offset = out_src_reg;
    assign pix_out.dst_byte_offset = out_dst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            c_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NSTG-2:0], pop};
            c_vld_reg   <= vld_reg[NSTG-1];
            m_vld_reg   <= c_vld_reg;
            out_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg[0]  <= ncrm_pkg::div_step(init_x, cfg_q.tgt_w);
            dy_reg[0]  <= ncrm_pkg::div_step(init_y, cfg_q.tgt_h);
            dst_reg[0] <= pop_item.dst_off;
            for (int k = 1; k < NSTG; k++)
            begin
                dx_reg[k]  <= ncrm_pkg::div_step(dx_reg[k-1], cfg_q.tgt_w);
                dy_reg[k]  <= ncrm_pkg::div_step(dy_reg[k-1], cfg_q.tgt_h);
                dst_reg[k] <= dst_reg[k-1];
            end

            c_sx_reg  <= clamp_axis(dx_reg[NSTG-1].nq, cfg_q.crop_left, cfg_q.src_w);
            c_sy_reg  <= clamp_axis(dy_reg[NSTG-1].nq, cfg_q.crop_top, cfg_q.src_h);
            c_dst_reg <= dst_reg[NSTG-1];

            m_sx_reg   <= c_sx_reg;
            m_sy_reg   <= c_sy_reg;
            m_prod_reg <= ncrm_pkg::PROD_W'(c_sy_reg) * ncrm_pkg::PROD_W'(cfg_q.src_w);
            m_dst_reg  <= c_dst_reg;

            out_col_reg <= m_sx_reg;
            out_row_reg <= m_sy_reg;
            out_src_reg <= ncrm_pkg::OFF_W'(src_sum * ncrm_pkg::BYTES_PER_PIXEL);
            out_dst_reg <= m_dst_reg;
        end
    end

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg) && $stable(c_vld_reg) && $stable(m_vld_reg))
        else $error("pipeline moved while output stalled");

    a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        adv && m_vld_reg |=> out_vld_reg)
        else $error("finished mapping dropped before output");

endmodule

[hw/rtl/nearest_crop_resize_mapper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_crop_resize_mapper
// Nearest-neighbour crop-and-resize address mapper (destination to source).
// ----------------------------------------------------------------------------
//  channel   role     carries
//  -------   ------   ----------------------------------------------------
//  cfg       sink     register index, write data (always ready)
//  pix_in    sink     out_col, out_row of one destination pixel
//  pix_out   source   in_col, in_row, src_byte_offset, dst_byte_offset
//
//  One request per cycle is taken and one result per cycle delivered while
//  the output is not stalled. From request to earliest result the path runs:
//  input stage, queue, one divider stage per quotient bit (25), clamp, source
//  multiply and the output register.
//  Reset restores the register defaults and empties every stage.
//  An output stall freezes the divider pipeline; the four-entry queue and
//  the input stage keep taking requests until they fill.
// ----------------------------------------------------------------------------
module nearest_crop_resize_mapper (
    input  logic          clk,
    input  logic          rst_n,
    ncrm_cfg_if.sink      cfg,
    ncrm_pix_in_if.sink   pix_in,
    ncrm_pix_out_if.source pix_out
);

    ncrm_pkg::ncrm_cfg_t       cfg_q;
    ncrm_pkg::ncrm_fifo_stat_t fifo_stat;
    ncrm_pkg::ncrm_item_t      push_item;
    ncrm_pkg::ncrm_item_t      pop_item;
    logic                      push;
    logic                      pop;

    ncrm_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    ncrm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .cfg_q     (cfg_q),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_item (push_item)
    );

    ncrm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (fifo_stat)
    );

    ncrm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_q     (cfg_q),
        .fifo_stat (fifo_stat),
        .pop_item  (pop_item),
        .pop       (pop),
        .pix_out   (pix_out)
    );

endmodule

[dv/ncrm_mapper_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrm_mapper_checker
// Watches the config and pixel channels of the crop-and-resize mapper, keeps
// a shadow of the window registers, works out the source coordinates and
// byte offsets of every accepted pixel request and scores the mapper's
// results against them in order.
// ----------------------------------------------------------------------------
module ncrm_mapper_checker (
    input  logic    clk,
    input  logic    rst_n,
    ncrm_cfg_if     cfg,
    ncrm_pix_in_if  pix_in,
    ncrm_pix_out_if pix_out,
    output int      mismatches,
    output int      outstanding
);

    typedef struct packed {
        logic [ncrm_pkg::COORD_W-1:0] in_col;
        logic [ncrm_pkg::COORD_W-1:0] in_row;
        logic [ncrm_pkg::OFF_W-1:0]   src_off;
        logic [ncrm_pkg::OFF_W-1:0]   dst_off;
    } mapping_t;

    logic [ncrm_pkg::REG_W-1:0] shadow_regs [8];
    mapping_t                   pending_maps [$];
    int                         fail_cnt = 0;

    // Zero reads as one, anything past the largest image saturates
    function automatic int clip_dim(input logic [ncrm_pkg::REG_W-1:0] v);
        int d;
        d = int'(v);
        if (d == 0)
            d = 1;
        else if (d > ncrm_pkg::MAX_DIM)
            d = ncrm_pkg::MAX_DIM;
        return d;
    endfunction

    function automatic logic [ncrm_pkg::COORD_W-1:0] axis_to_source(
        input logic [ncrm_pkg::POS_W-1:0]        pos,
        input int                                span,
        input int                                tgt,
        input logic signed [ncrm_pkg::REG_W-1:0] origin,
        input int                                size
    );
        longint s;
        s = longint'(origin) + (longint'(pos) * span) / tgt;
        if (s < 0)
            s = 0;
        if (s > size - 1)
            s = size - 1;
        return s[ncrm_pkg::COORD_W-1:0];
    endfunction

    function automatic mapping_t predict_mapping(input logic [ncrm_pkg::POS_W-1:0] col,
                                                 input logic [ncrm_pkg::POS_W-1:0] row);
        int       src_w;
        int       tgt_w;
        longint   src_lin;
        longint   dst_lin;
        mapping_t m;
        src_w    = clip_dim(shadow_regs[ncrm_pkg::REG_SOURCE_WIDTH]);
        tgt_w    = clip_dim(shadow_regs[ncrm_pkg::REG_TARGET_WIDTH]);
        m.in_col = axis_to_source(col, clip_dim(shadow_regs[ncrm_pkg::REG_CROP_SPAN_X]),
                                  tgt_w, shadow_regs[ncrm_pkg::REG_CROP_LEFT], src_w);
        m.in_row = axis_to_source(row, clip_dim(shadow_regs[ncrm_pkg::REG_CROP_SPAN_Y]),
                                  clip_dim(shadow_regs[ncrm_pkg::REG_TARGET_HEIGHT]),
                                  shadow_regs[ncrm_pkg::REG_CROP_TOP],
                                  clip_dim(shadow_regs[ncrm_pkg::REG_SOURCE_HEIGHT]));
        src_lin   = (longint'(m.in_row) * src_w + m.in_col) * ncrm_pkg::BYTES_PER_PIXEL;
        dst_lin   = (longint'(row) * tgt_w + col) * ncrm_pkg::BYTES_PER_PIXEL;
        m.src_off = src_lin[ncrm_pkg::OFF_W-1:0];
        m.dst_off = dst_lin[ncrm_pkg::OFF_W-1:0];
        return m;
    endfunction

    task automatic flag_result(input string what, input mapping_t want, input mapping_t got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t mapper %s: expected col %0d row %0d src %0d dst %0d,",
                     $time, what, want.in_col, want.in_row, want.src_off, want.dst_off,
                     " got col %0d row %0d src %0d dst %0d",
                     got.in_col, got.in_row, got.src_off, got.dst_off);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mapping_t got;
        mapping_t want;
        if (!rst_n)
        begin
            shadow_regs[ncrm_pkg::REG_SOURCE_WIDTH]  <= 13'd640;
            shadow_regs[ncrm_pkg::REG_SOURCE_HEIGHT] <= 13'd480;
            shadow_regs[ncrm_pkg::REG_TARGET_WIDTH]  <= 13'd112;
            shadow_regs[ncrm_pkg::REG_TARGET_HEIGHT] <= 13'd112;
            shadow_regs[ncrm_pkg::REG_CROP_LEFT]     <= 13'd0;
            shadow_regs[ncrm_pkg::REG_CROP_TOP]      <= 13'd0;
            shadow_regs[ncrm_pkg::REG_CROP_SPAN_X]   <= 13'd640;
            shadow_regs[ncrm_pkg::REG_CROP_SPAN_Y]   <= 13'd480;
            pending_maps.delete();
            mismatches  <= fail_cnt;
            outstanding <= 0;
        end
        else
        begin
            // a result cannot belong to the request taken on the same edge
            if (pix_out.valid && pix_out.ready)
            begin
                got.in_col  = pix_out.in_col;
                got.in_row  = pix_out.in_row;
                got.src_off = pix_out.src_byte_offset;
                got.dst_off = pix_out.dst_byte_offset;
                if (pending_maps.size() == 0)
                begin
                    flag_result("result with nothing outstanding", '0, got);
                end
                else
                begin
                    want = pending_maps.pop_front();
                    if (got.in_col != want.in_col || got.in_row != want.in_row ||
                        got.src_off != want.src_off || got.dst_off != want.dst_off)
                        flag_result("mismatch", want, got);
                end
            end
            if (pix_in.valid && pix_in.ready)
                pending_maps.push_back(predict_mapping(pix_in.out_col, pix_in.out_row));
            if (cfg.valid && cfg.ready)
                shadow_regs[cfg.index] <= cfg.data;
            mismatches  <= fail_cnt;
            outstanding <= pending_maps.size();
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the crop-and-resize mapper: directed windows covering the
// register extremes, zero and oversized sizes and clamping at both image
// edges, then random windows with mostly in-range pixel requests. Both
// channels stall at random and the result side holds off once for a long
// stretch so the mapper backs up. Scoring is done by ncrm_mapper_checker.
// ----------------------------------------------------------------------------
module tb;

    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 60;
    localparam int HOLD_CYCLES   = 300;

    logic clk;
    logic rst_n;
    bit   hold_req = 1'b0;
    int   mismatches;
    int   outstanding;

    ncrm_cfg_if     cfg_bus ();
    ncrm_pix_in_if  pix_req ();
    ncrm_pix_out_if pix_rsp ();

    nearest_crop_resize_mapper uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .pix_in  (pix_req),
        .pix_out (pix_rsp)
    );

    ncrm_mapper_checker map_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_bus),
        .pix_in      (pix_req),
        .pix_out     (pix_rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap(input bit gapless);
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [ncrm_pkg::REG_W-1:0] rand_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 8)
            return ncrm_pkg::REG_W'($urandom_range(ncrm_pkg::MAX_DIM + 1, 8191));
        if (r < 20)
            return ncrm_pkg::REG_W'($urandom_range(1, ncrm_pkg::MAX_DIM));
        return ncrm_pkg::REG_W'($urandom_range(1, 160));
    endfunction

    function automatic logic [ncrm_pkg::REG_W-1:0] rand_origin();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return ncrm_pkg::REG_W'($urandom_range(0, 8191));
        return ncrm_pkg::REG_W'($urandom_range(0, 200) - 100);
    endfunction

    // Highest in-range coordinate for a size as written; zero or oversized sizes get the full field
    function automatic int coord_hi(input logic [ncrm_pkg::REG_W-1:0] v);
        if (v >= 1 && v <= ncrm_pkg::MAX_DIM)
            return int'(v) - 1;
        return 4095;
    endfunction

    task automatic drain_results();
        pix_req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ncrm_pkg::ncrm_reg_idx_t idx,
                             input logic [ncrm_pkg::REG_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
    endtask

    task automatic load_window(input logic [ncrm_pkg::REG_W-1:0] sw, sh, tw, th,
                               cl, ct, cx, cy);
        drain_results();
        write_reg(ncrm_pkg::REG_SOURCE_WIDTH, sw);
        write_reg(ncrm_pkg::REG_SOURCE_HEIGHT, sh);
        write_reg(ncrm_pkg::REG_TARGET_WIDTH, tw);
        write_reg(ncrm_pkg::REG_TARGET_HEIGHT, th);
        write_reg(ncrm_pkg::REG_CROP_LEFT, cl);
        write_reg(ncrm_pkg::REG_CROP_TOP, ct);
        write_reg(ncrm_pkg::REG_CROP_SPAN_X, cx);
        write_reg(ncrm_pkg::REG_CROP_SPAN_Y, cy);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_pixel(input int col, input int row, input int gap);
        pix_req.valid   <= 1'b1;
        pix_req.out_col <= ncrm_pkg::POS_W'(col);
        pix_req.out_row <= ncrm_pkg::POS_W'(row);
        @(posedge clk);
        while (!pix_req.ready)
            @(posedge clk);
        if (gap > 0)
        begin
            pix_req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off on request
    initial
    begin
        int r;
        int span;
        int cyc;
        pix_rsp.ready <= 1'b0;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                pix_rsp.ready <= 1'b0;
                span = HOLD_CYCLES;
            end
            else if (cyc % 500 < 120)
            begin
                pix_rsp.ready <= 1'b1;
                span = 1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    pix_rsp.ready <= 1'b1;
                    span = $urandom_range(1, 4);
                end
                else if (r < 93)
                begin
                    pix_rsp.ready <= 1'b0;
                    span = $urandom_range(1, 3);
                end
                else
                begin
                    pix_rsp.ready <= 1'b0;
                    span = $urandom_range(10, 40);
                end
            end
            cyc += span;
            repeat (span) @(posedge clk);
        end
    end

    initial
    begin
        logic [ncrm_pkg::REG_W-1:0] tw;
        logic [ncrm_pkg::REG_W-1:0] th;
        int                         col_hi;
        int                         row_hi;
        int                         r;
        bit                         gapless;

        rst_n           <= 1'b0;
        cfg_bus.valid   <= 1'b0;
        cfg_bus.index   <= ncrm_pkg::REG_SOURCE_WIDTH;
        cfg_bus.data    <= '0;
        pix_req.valid   <= 1'b0;
        pix_req.out_col <= '0;
        pix_req.out_row <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window: corners, last in-range pixel and pixels past the target
        send_pixel(0, 0, pick_gap(0));
        send_pixel(111, 111, pick_gap(0));
        send_pixel(112, 112, pick_gap(0));
        send_pixel(4095, 4095, pick_gap(0));
        send_pixel(56, 0, pick_gap(0));
        send_pixel(0, 56, pick_gap(0));
        send_pixel(4095, 0, pick_gap(0));

        // full-size identity map
        load_window(13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd0, 13'd0, 13'd4096, 13'd4096);
        send_pixel(0, 0, 0);
        send_pixel(4095, 4095, 0);
        send_pixel(2730, 1365, 0);
        send_pixel(1, 4094, 0);

        // all sizes zero: treated as one, everything lands on pixel 0
        load_window(13'd0, 13'd0, 13'd0, 13'd0, 13'h0FFF, 13'h1FFF, 13'd0, 13'd0);
        send_pixel(0, 0, pick_gap(0));
        send_pixel(4095, 4095, pick_gap(0));
        send_pixel(7, 3, pick_gap(0));

        // oversized sizes saturate; origin at the most negative and most positive
        load_window(13'd4097, 13'd8191, 13'd8191, 13'd8191, 13'h1000, 13'h0FFF,
                    13'd8191, 13'd8191);
        send_pixel(0, 0, 0);
        send_pixel(4095, 4095, 0);
        send_pixel(2048, 100, 0);
        send_pixel(4095, 0, 0);

        // tiny image with the crop hanging over both edges
        load_window(13'd17, 13'd9, 13'd5, 13'd3, 13'h1FFD, 13'h1FFF, 13'd23, 13'd14);
        send_pixel(0, 0, pick_gap(0));
        send_pixel(1, 1, pick_gap(0));
        send_pixel(4, 2, pick_gap(0));
        send_pixel(5, 3, pick_gap(0));
        send_pixel(3, 2, pick_gap(0));
        send_pixel(4095, 4095, pick_gap(0));

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            tw = rand_dim();
            th = rand_dim();
            load_window(rand_dim(), rand_dim(), tw, th, rand_origin(), rand_origin(),
                        rand_dim(), rand_dim());
            col_hi  = coord_hi(tw);
            row_hi  = coord_hi(th);
            gapless = (ph % 3 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // back the mapper up while requests keep coming
                if (ph == 2 && k == 5)
                    hold_req = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 10)
                    send_pixel(col_hi, row_hi, pick_gap(gapless));
                else if (r < 88)
                    send_pixel($urandom_range(0, col_hi), $urandom_range(0, row_hi),
                               pick_gap(gapless));
                else
                    send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                               pick_gap(gapless));
            end
        end

        drain_results();
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
